@@ sv/ksc_pkg.sv @@
`timescale 1ns / 1ps
package ksc_pkg;

  // Category codes, in priority order.
  typedef enum logic [2:0] {
    CAT_ROAD     = 3'd0,
    CAT_WATER    = 3'd1,
    CAT_FOREST   = 3'd2,
    CAT_FARMLAND = 3'd3,
    CAT_ROCK     = 3'd4,
    CAT_DIRT     = 3'd5,
    CAT_GRASS    = 3'd6,
    CAT_UNKNOWN  = 3'd7
  } category_t;

  localparam int NumCats   = 7;
  localparam int NumRegs   = 8;
  localparam int WinDepth  = 7;
  localparam int TailBytes = WinDepth + 1;
  localparam int NumKw     = 17;
  localparam int ColourW   = 24;
  localparam int RegIdxW   = 3;

  typedef logic [NumCats-1:0]     hits_t;
  typedef logic [8*TailBytes-1:0] tail_t;
  typedef logic [ColourW-1:0]     colour_t;

  // Control from the top level to the matcher.
  typedef struct packed {
    logic step;
    logic last;
  } ksc_ctrl_t;

  // Keyword text, right aligned: the final character sits in the low byte.
  localparam tail_t KwText [NumKw] = '{
    64'("road"), 64'("asphalt"), 64'("concrete"), 64'("runway"),
    64'("water"), 64'("sea"), 64'("ocean"),
    64'("forest"), 64'("tree"),
    64'("crop"), 64'("field"),
    64'("rock"), 64'("stone"),
    64'("dirt"), 64'("soil"), 64'("sand"),
    64'("grass")
  };

  localparam int KwLen [NumKw] = '{4, 7, 8, 6, 5, 3, 5, 6, 4, 4, 5, 4, 5, 4, 4, 4, 5};

  localparam category_t KwCat [NumKw] = '{
    CAT_ROAD, CAT_ROAD, CAT_ROAD, CAT_ROAD,
    CAT_WATER, CAT_WATER, CAT_WATER,
    CAT_FOREST, CAT_FOREST,
    CAT_FARMLAND, CAT_FARMLAND,
    CAT_ROCK, CAT_ROCK,
    CAT_DIRT, CAT_DIRT, CAT_DIRT,
    CAT_GRASS
  };

  localparam colour_t ColourReset [NumRegs] = '{
    24'h404040, 24'h1E90FF, 24'h006400, 24'h9ACD32,
    24'h808080, 24'h8B7765, 24'h228B22, 24'hFFFFFF
  };

  // ASCII upper case to lower case; other values pass unchanged.
  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

  // Hit bits for every keyword that ends at the newest byte of the tail.
  function automatic hits_t match_tail(input tail_t tail);
    hits_t h;
    tail_t mask;
    h = '0;
    for (int k = 0; k < NumKw; k++) begin
      mask = '0;
      for (int i = 0; i < TailBytes; i++) begin
        if (i < KwLen[k]) begin
          mask[8*i +: 8] = 8'hFF;
        end
      end
      if ((tail & mask) == KwText[k]) begin
        h[KwCat[k]] = 1'b1;
      end
    end
    return h;
  endfunction

  // First hit in priority order, else unknown.
  function automatic category_t pick_category(input hits_t h);
    category_t c;
    c = CAT_UNKNOWN;
    for (int i = NumCats - 1; i >= 0; i--) begin
      if (h[i]) begin
        c = category_t'(i);
      end
    end
    return c;
  endfunction

endpackage

@@ sv/ksc_match.sv @@
`timescale 1ns / 1ps
module ksc_match (
  input  logic               clk,
  input  logic               rst,
  input  ksc_pkg::ksc_ctrl_t ctrl,
  input  logic [7:0]         cur_byte,
  output ksc_pkg::hits_t     hits_now
);
  import ksc_pkg::*;

  logic [8*WinDepth-1:0] window;
  hits_t                 hits;

  // Current byte in the low byte, older bytes above it.
  assign hits_now = hits | match_tail({window, cur_byte});

  // Shift the window on each byte; clear everything after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      hits   <= '0;
    end else if (ctrl.step) begin
      if (ctrl.last) begin
        window <= '0;
        hits   <= '0;
      end else begin
        window <= {window[8*(WinDepth-1)-1:0], cur_byte};
        hits   <= hits_now;
      end
    end
  end

  // Sticky hits never drop within a name.
  a_hits_sticky: assert property (@(posedge clk) disable iff (rst)
    ctrl.step && !ctrl.last |=> (hits & $past(hits)) == $past(hits))
    else $error("category hits lost within a name");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    ctrl.step && ctrl.last |=> hits == '0 && window == '0)
    else $error("state not cleared after last byte");

endmodule

@@ sv/ksc_cfg.sv @@
`timescale 1ns / 1ps
module ksc_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [ksc_pkg::RegIdxW-1:0] wr_index,
  input  ksc_pkg::colour_t            wr_data,
  input  ksc_pkg::category_t          sel,
  output ksc_pkg::colour_t            colour
);
  import ksc_pkg::*;

  colour_t regs [NumRegs];

  // Colour registers, written one at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) begin
        regs[i] <= ColourReset[i];
      end
    end else if (wr_en) begin
      regs[wr_index] <= wr_data;
    end
  end

  // Colour of the selected category.
  assign colour = regs[sel];

endmodule

@@ sv/keyword_surface_classifier_unit.sv @@
`timescale 1ns / 1ps
// Channel   Fields (low bit first)                           Handshake
// s_axis    tdata: name_byte[7:0]; tlast: last_byte          s_tvalid / s_tready
// m_axis    tdata: category[2:0] red[10:3] green[18:11]      m_tvalid / m_tready
//           blue[26:19], zero fill [31:27]
// cfg       wr_index selects colour register 0..7            wr_en, no wait
//
// One byte per cycle sustained; each byte passes through the input register,
// and the last byte's result enters the output register as that byte leaves
// it. Synchronous reset clears the window, hits and valids and reloads the
// colour defaults. A last byte waits in the input register while an earlier
// result is held by m_tready low; other bytes pass regardless of the output.
module keyword_surface_classifier_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [7:0]                  s_tdata,   // name_byte[7:0]
  input  logic                        s_tlast,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  output logic [31:0]                 m_tdata,   // category, red, green, blue
  output logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic                        wr_en,
  input  logic [ksc_pkg::RegIdxW-1:0] wr_index,
  input  ksc_pkg::colour_t            wr_data
);
  import ksc_pkg::*;

  logic       in_valid;
  logic       in_last;
  logic [7:0] in_byte;
  logic       out_free;
  logic       advance;
  ksc_ctrl_t  ctrl;
  hits_t      hits_now;
  category_t  cat;
  colour_t    colour;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || advance;
  assign ctrl     = '{step: advance, last: in_last};

  // Input register holds the folded byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= fold_byte(s_tdata);
      in_last <= s_tlast;
    end
  end

  ksc_match u_match (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .cur_byte (in_byte),
    .hits_now (hits_now)
  );

  assign cat = pick_category(hits_now);

  ksc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .sel      (cat),
    .colour   (colour)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      m_tdata <= {5'd0, colour[7:0], colour[15:8], colour[23:16], cat};
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !(advance && in_last))
    else $error("held result overwritten");

  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> m_tvalid)
    else $error("last byte produced no result");

  a_mid_byte_no_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_last |-> s_tready && advance)
    else $error("non-last byte stalled");

endmodule
